// ===== rtl/core/frq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frq_pkg
// Shared types and constants for the FIR frequency response evaluator.
// ----------------------------------------------------------------------------
package frq_pkg;

   localparam int TAP_IDX_W  = 8;
   localparam int COEF_W     = 16;
   localparam int POINT_W    = 10;
   localparam int OUT_W      = 24;
   localparam int NTAPS_W    = 9;
   localparam int NPOINTS_W  = 11;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 11;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_TAPS   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_POINTS = 1'b1;

   localparam logic [NTAPS_W-1:0]   NUM_TAPS_RST   = 9'd256;
   localparam logic [NPOINTS_W-1:0] NUM_POINTS_RST = 11'd512;

   localparam longint unsigned PI_Q30 = 64'd3373259426;

   localparam logic signed [OUT_W-1:0] OUT_MAX = 24'sh7FFFFF;
   localparam logic signed [OUT_W-1:0] OUT_MIN = -24'sh800000;

   typedef struct packed {
      logic                     is_query;
      logic [TAP_IDX_W-1:0]     tap_index;
      logic signed [COEF_W-1:0] coefficient;
      logic [POINT_W-1:0]       point;
      logic                     oor;
   } entry_type;

   typedef struct packed {
      logic pop;
      logic clearing;
   } back_ctl_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_MAC,
      ST_DRAIN,
      ST_FINISH
   } state_type;

endpackage

// ===== rtl/core/frq_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frq interfaces
// Request, response and register-write channels with valid/ready.
// ----------------------------------------------------------------------------
interface frq_req_if import frq_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     kind;
   logic [TAP_IDX_W-1:0]     tap_index;
   logic signed [COEF_W-1:0] coefficient;
   logic [POINT_W-1:0]       point_index;
   modport source (output valid, kind, tap_index, coefficient, point_index, input ready);
   modport sink   (input valid, kind, tap_index, coefficient, point_index, output ready);
endinterface

interface frq_rsp_if import frq_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] real_part;
   logic signed [OUT_W-1:0] imag_part;
   logic [POINT_W-1:0]      echoed_point;
   logic                    out_of_range;
   modport source (output valid, real_part, imag_part, echoed_point, out_of_range,
                   input ready);
   modport sink   (input valid, real_part, imag_part, echoed_point, out_of_range,
                   output ready);
endinterface

interface frq_csr_if import frq_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/fir_frequency_response.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir_frequency_response
// Frequency response of a stored FIR filter at evenly spaced points, 0 to pi.
// ----------------------------------------------------------------------------
// After reset the coefficient store is cleared entry by entry, during which
// no request is taken. A load with an in-range tap index is written as it
// leaves the queue. A query runs the bit-serial phase step divider, then steps
// through the taps with the single multiply-accumulate pair, then drains the
// pipeline and rounds; an out-of-range point skips the divider and the taps.
// A two-entry queue lets requests arrive while a query runs, and the response
// register lets the next query run while a result waits to be taken.
module fir_frequency_response import frq_pkg::*; #(
   parameter int MAX_TAPS   = 256,
   parameter int MAX_POINTS = 1024,
   parameter int PHASE_BITS = 12
) (
   input  logic       clock,
   input  logic       reset,
   frq_req_if.sink    req_bus,
   frq_rsp_if.source  rsp_bus,
   frq_csr_if.sink    csr_bus
);

   localparam int PNT_W  = $clog2(MAX_POINTS + 1);
   localparam int TCNT_W = $clog2(MAX_TAPS + 1);
   localparam int PC_W   = ((PNT_W > NPOINTS_W) ? PNT_W : NPOINTS_W) + 1;
   localparam int TC_W   = ((TCNT_W > NTAPS_W) ? TCNT_W : NTAPS_W) + 1;

   logic [NTAPS_W-1:0]   num_taps_ff;
   logic [NPOINTS_W-1:0] num_points_ff;
   logic [PNT_W-1:0]     p_eff;
   logic [TCNT_W-1:0]    taps_eff;
   back_ctl_type         back_ctl;
   logic                 q_valid;
   entry_type            q_entry;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_taps_ff   <= NUM_TAPS_RST;
         num_points_ff <= NUM_POINTS_RST;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_NUM_TAPS:   num_taps_ff   <= NTAPS_W'(csr_bus.data);
            CSR_NUM_POINTS: num_points_ff <= NPOINTS_W'(csr_bus.data);
            default: ;
         endcase
      end
   end

   always_comb begin
      if (PC_W'(num_points_ff) < PC_W'(2)) begin
         p_eff = PNT_W'(2);
      end else if (PC_W'(num_points_ff) > PC_W'(MAX_POINTS)) begin
         p_eff = PNT_W'(MAX_POINTS);
      end else begin
         p_eff = PNT_W'(num_points_ff);
      end
      if (TC_W'(num_taps_ff) > TC_W'(MAX_TAPS)) begin
         taps_eff = TCNT_W'(MAX_TAPS);
      end else begin
         taps_eff = TCNT_W'(num_taps_ff);
      end
   end

   frq_front #(
      .PNT_W (PNT_W)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .p_eff    (p_eff),
      .back_ctl (back_ctl),
      .q_valid  (q_valid),
      .q_entry  (q_entry)
   );

   frq_back #(
      .MAX_TAPS   (MAX_TAPS),
      .PHASE_BITS (PHASE_BITS),
      .PNT_W      (PNT_W),
      .TCNT_W     (TCNT_W)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_entry  (q_entry),
      .p_eff    (p_eff),
      .taps_eff (taps_eff),
      .back_ctl (back_ctl),
      .rsp_bus  (rsp_bus)
   );

endmodule

// ===== rtl/core/frq_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frq_front
// Accepts request transactions, flags out-of-range points, two-entry queue.
// ----------------------------------------------------------------------------
module frq_front import frq_pkg::*; #(
   parameter int PNT_W = 11
) (
   input  logic             clock,
   input  logic             reset,
   frq_req_if.sink          req_bus,
   input  logic [PNT_W-1:0] p_eff,
   input  back_ctl_type     back_ctl,
   output logic             q_valid,
   output entry_type        q_entry
);

   localparam int CMP_W = ((PNT_W > POINT_W) ? PNT_W : POINT_W) + 1;

   entry_type  mem_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   entry_type  new_entry;

   assign req_bus.ready = !back_ctl.clearing && (cnt_ff != 2'd2);
   assign push          = req_bus.valid && req_bus.ready;

   always_comb begin
      new_entry.is_query    = (req_bus.kind == KIND_QUERY);
      new_entry.tap_index   = req_bus.tap_index;
      new_entry.coefficient = req_bus.coefficient;
      new_entry.point       = req_bus.point_index;
      new_entry.oor         = (CMP_W'(req_bus.point_index) >= CMP_W'(p_eff));
   end

   assign q_valid = (cnt_ff != 2'd0);
   assign q_entry = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? !wr_ff : wr_ff;
      rd_in  = back_ctl.pop ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(back_ctl.pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= new_entry;
      end
   end

endmodule

// ===== rtl/core/frq_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frq_back
// Executes queued transactions: coefficient writes and response sums.
// ----------------------------------------------------------------------------
module frq_back import frq_pkg::*; #(
   parameter int MAX_TAPS   = 256,
   parameter int PHASE_BITS = 12,
   parameter int PNT_W      = 11,
   parameter int TCNT_W     = 9
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  entry_type         q_entry,
   input  logic [PNT_W-1:0]  p_eff,
   input  logic [TCNT_W-1:0] taps_eff,
   output back_ctl_type      back_ctl,
   frq_rsp_if.source         rsp_bus
);

   localparam int TAP_AW   = $clog2(MAX_TAPS);
   localparam int TCMP_W   = ((TCNT_W > TAP_IDX_W) ? TCNT_W : TAP_IDX_W) + 1;
   localparam int QUARTER  = 1 << (PHASE_BITS - 2);
   localparam int RA_W     = PHASE_BITS - 1;
   localparam int D_W      = PNT_W + 1;
   localparam int DVD_W    = POINT_W + PHASE_BITS;
   localparam int DC_W     = $clog2(DVD_W + 1);
   localparam int PROD_W   = 33;
   localparam int ACC_W    = 34 + TAP_AW;
   localparam int SH_W     = ACC_W - 15;

   // ceil(2^64 / ((2i)(2i+1))) for the series terms, exact for 32-bit terms
   localparam logic [127:0] SER_RCP [6] = '{
      ((128'd1 << 64) + 128'd5) / 128'd6,
      ((128'd1 << 64) + 128'd19) / 128'd20,
      ((128'd1 << 64) + 128'd41) / 128'd42,
      ((128'd1 << 64) + 128'd71) / 128'd72,
      ((128'd1 << 64) + 128'd109) / 128'd110,
      ((128'd1 << 64) + 128'd155) / 128'd156
   };

   typedef logic [14:0] sine_rom_type [QUARTER + 1];

   function automatic sine_rom_type gen_sine();
      sine_rom_type      t;
      longint unsigned   x;
      longint unsigned   x2;
      longint unsigned   term;
      longint            s;
      logic [127:0]      wide;
      int                i;
      int                j;
      for (j = 0; j <= QUARTER; j++) begin
         x    = (PI_Q30 * longint'(j) + (64'd1 << (PHASE_BITS - 2))) >> (PHASE_BITS - 1);
         x2   = (x * x) >> 30;
         term = x;
         s    = longint'(x);
         for (i = 1; i <= 6; i++) begin
            term = (term * x2) >> 30;
            wide = 128'(term) * SER_RCP[i - 1];
            term = wide[127:64];
            if (i % 2 == 1) begin
               s = s - longint'(term);
            end else begin
               s = s + longint'(term);
            end
         end
         if (s < 0) begin
            s = 0;
         end
         s = (s + 16384) >>> 15;
         if (s > 32767) begin
            s = 32767;
         end
         t[j] = 15'(s);
      end
      return t;
   endfunction

   localparam sine_rom_type SINE_ROM = gen_sine();

   function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SH_W-1:0] v);
      logic signed [OUT_W-1:0] r;
      if (v > SH_W'(OUT_MAX)) begin
         r = OUT_MAX;
      end else if (v < SH_W'(OUT_MIN)) begin
         r = OUT_MIN;
      end else begin
         r = OUT_W'(v);
      end
      return r;
   endfunction

   state_type state_ff, state_in;

   // control flags
   logic issue, q_pop, out_load, do_load, start_query, clr_done, div_done, out_free;

   logic [TAP_AW-1:0]     clr_ff;
   logic signed [COEF_W-1:0] coef_mem [MAX_TAPS];

   logic [POINT_W-1:0]    k_ff;
   logic                  oor_ff;
   logic [D_W-1:0]        d;
   logic [DVD_W-1:0]      dvd_ff;
   logic [D_W-1:0]        rem_ff;
   logic [PHASE_BITS-1:0] quo_ff;
   logic [DC_W-1:0]       dcnt_ff;
   logic [D_W:0]          trial;
   logic                  trial_ge;
   logic [D_W-1:0]        rem_in;

   logic [PHASE_BITS-1:0] ph_ff, ph_in;
   logic [D_W-1:0]        r_ff, r_in;
   logic [D_W:0]          r_sum;
   logic                  r_wrap;
   logic [TAP_AW-1:0]     n_ff;
   logic [TCNT_W-1:0]     left_ff;

   logic [PHASE_BITS-1:0] cph;
   logic [RA_W-1:0]       sin_addr, cos_addr;
   logic [14:0]           sin_rd_ff, cos_rd_ff;
   logic signed [COEF_W-1:0] coef_rd_ff;
   logic                  sneg_ff, cneg_ff, v1_ff, v2_ff;
   logic signed [16:0]    sin_s, cos_s;
   logic signed [PROD_W-1:0] pre_ff, pim_ff;
   logic signed [ACC_W-1:0]  are_ff, aim_ff;
   logic signed [ACC_W-1:0]  are_rnd, aim_rnd;
   logic signed [SH_W-1:0]   are_sh, aim_sh;

   logic                    ov_ff;
   logic signed [OUT_W-1:0] ore_ff, oim_ff;
   logic [POINT_W-1:0]      ok_ff;
   logic                    ooor_ff;

   assign clr_done = (clr_ff == TAP_AW'(MAX_TAPS - 1));
   assign div_done = (dcnt_ff == DC_W'(DVD_W - 1));
   assign out_free = !ov_ff || rsp_bus.ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (q_valid && q_entry.is_query) begin
               state_in = q_entry.oor ? ST_FINISH : ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) state_in = (taps_eff == '0) ? ST_FINISH : ST_MAC;
         end
         ST_MAC: begin
            if (left_ff == TCNT_W'(1)) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!v1_ff && !v2_ff) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      q_pop       = (state_ff == ST_IDLE) && q_valid;
      do_load     = q_pop && !q_entry.is_query &&
                    (TCMP_W'(q_entry.tap_index) < TCMP_W'(MAX_TAPS));
      start_query = q_pop && q_entry.is_query;
      issue       = (state_ff == ST_MAC);
      out_load    = (state_ff == ST_FINISH) && out_free;
      back_ctl.pop      = q_pop;
      back_ctl.clearing = (state_ff == ST_CLEAR);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + TAP_AW'(1);
         v1_ff <= issue;
         v2_ff <= v1_ff;
         if (out_load) begin
            ov_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            ov_ff <= 1'b0;
         end
      end
   end

   // coefficient store
   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR) begin
         coef_mem[clr_ff] <= '0;
      end else if (do_load) begin
         coef_mem[TAP_AW'(q_entry.tap_index)] <= q_entry.coefficient;
      end
      coef_rd_ff <= coef_mem[n_ff];
   end

   // phase divider: (k << PHASE_BITS) / d
   assign d        = {PNT_W'(p_eff - PNT_W'(1)), 1'b0};
   assign trial    = {rem_ff, dvd_ff[DVD_W-1]};
   assign trial_ge = (trial >= {1'b0, d});
   assign rem_in   = trial_ge ? D_W'(trial - {1'b0, d}) : D_W'(trial);

   assign r_sum  = {1'b0, r_ff} + {1'b0, rem_ff};
   assign r_wrap = (r_sum >= {1'b0, d});
   assign r_in   = r_wrap ? D_W'(r_sum - {1'b0, d}) : D_W'(r_sum);
   assign ph_in  = ph_ff + quo_ff + PHASE_BITS'(r_wrap);

   always_ff @(posedge clock) begin
      if (start_query) begin
         k_ff    <= q_entry.point;
         oor_ff  <= q_entry.oor;
         dvd_ff  <= {q_entry.point, PHASE_BITS'(0)};
         rem_ff  <= '0;
         quo_ff  <= '0;
         dcnt_ff <= '0;
         are_ff  <= '0;
         aim_ff  <= '0;
      end else begin
         if (state_ff == ST_DIV) begin
            dvd_ff  <= dvd_ff << 1;
            rem_ff  <= rem_in;
            quo_ff  <= {quo_ff[PHASE_BITS-2:0], trial_ge};
            dcnt_ff <= dcnt_ff + DC_W'(1);
            ph_ff   <= '0;
            r_ff    <= D_W'(p_eff - PNT_W'(1));
            n_ff    <= '0;
            left_ff <= taps_eff;
         end
         if (issue) begin
            ph_ff   <= ph_in;
            r_ff    <= r_in;
            n_ff    <= n_ff + TAP_AW'(1);
            left_ff <= left_ff - TCNT_W'(1);
         end
         if (v2_ff) begin
            are_ff <= are_ff + ACC_W'(pre_ff);
            aim_ff <= aim_ff + ACC_W'(pim_ff);
         end
      end
   end

   // sine table lookups
   assign cph      = ph_ff + PHASE_BITS'(QUARTER);
   assign sin_addr = ph_ff[PHASE_BITS-2] ?
                     RA_W'(QUARTER) - RA_W'(ph_ff[PHASE_BITS-3:0]) :
                     RA_W'(ph_ff[PHASE_BITS-3:0]);
   assign cos_addr = cph[PHASE_BITS-2] ?
                     RA_W'(QUARTER) - RA_W'(cph[PHASE_BITS-3:0]) :
                     RA_W'(cph[PHASE_BITS-3:0]);

   always_ff @(posedge clock) begin
      sin_rd_ff <= SINE_ROM[sin_addr];
      cos_rd_ff <= SINE_ROM[cos_addr];
      sneg_ff   <= ph_ff[PHASE_BITS-1];
      cneg_ff   <= cph[PHASE_BITS-1];
   end

   assign sin_s = sneg_ff ? -$signed({2'b00, sin_rd_ff}) : $signed({2'b00, sin_rd_ff});
   assign cos_s = cneg_ff ? -$signed({2'b00, cos_rd_ff}) : $signed({2'b00, cos_rd_ff});

   always_ff @(posedge clock) begin
      pre_ff <= coef_rd_ff * cos_s;
      pim_ff <= -(coef_rd_ff * sin_s);
   end

   // round half up to Q9.15 and saturate
   assign are_rnd = are_ff + ACC_W'(16384);
   assign aim_rnd = aim_ff + ACC_W'(16384);
   assign are_sh  = SH_W'(are_rnd >>> 15);
   assign aim_sh  = SH_W'(aim_rnd >>> 15);

   always_ff @(posedge clock) begin
      if (out_load) begin
         ore_ff  <= sat_out(are_sh);
         oim_ff  <= sat_out(aim_sh);
         ok_ff   <= k_ff;
         ooor_ff <= oor_ff;
      end
   end

   assign rsp_bus.valid        = ov_ff;
   assign rsp_bus.real_part    = ore_ff;
   assign rsp_bus.imag_part    = oim_ff;
   assign rsp_bus.echoed_point = ok_ff;
   assign rsp_bus.out_of_range = ooor_ff;

endmodule
